/* src/ncl_pkg.sv */
// ncl_pkg: shared types and constants for the numeric constant lexer.
// Used by ncl_step, ncl_obuf and numeric_constant_lexer_top; no dependencies.
`default_nettype none

package ncl_pkg;

    typedef enum logic [2:0] {
        ST_START   = 3'd0,
        ST_MINUS   = 3'd1,
        ST_ZERO    = 3'd2,
        ST_POINT   = 3'd3,
        ST_MANT    = 3'd4,
        ST_EXP     = 3'd5,
        ST_EXPSIGN = 3'd6,
        ST_EXPDIG  = 3'd7
    } t_lex_state;

    typedef logic [2:0] t_status;
    typedef logic [1:0] t_kind;

    localparam t_status S_TAKEN       = 3'd0;
    localparam t_status S_ENDED       = 3'd1;
    localparam t_status S_NEGATE      = 3'd2;
    localparam t_status S_POSSIBLE    = 3'd3;
    localparam t_status S_ERR_ZERO    = 3'd4;
    localparam t_status S_ERR_POINT   = 3'd5;
    localparam t_status S_ERR_EXP     = 3'd6;
    localparam t_status S_ERR_EXPSIGN = 3'd7;

    localparam t_kind K_NONE = 2'd0;
    localparam t_kind K_INT  = 2'd1;
    localparam t_kind K_DBL  = 2'd2;

    localparam logic [7:0] C_ZERO    = 8'h30;
    localparam logic [7:0] C_NINE    = 8'h39;
    localparam logic [7:0] C_MINUS   = 8'h2D;
    localparam logic [7:0] C_PLUS    = 8'h2B;
    localparam logic [7:0] C_POINT   = 8'h2E;
    localparam logic [7:0] C_UPPER_E = 8'h45;
    localparam logic [7:0] C_LOWER_E = 8'h65;
    localparam logic [7:0] C_UPPER_A = 8'h41;
    localparam logic [7:0] C_UPPER_Z = 8'h5A;
    localparam logic [7:0] C_LOWER_A = 8'h61;
    localparam logic [7:0] C_LOWER_Z = 8'h7A;

    typedef struct packed {
        t_status status;
        t_kind   kind;
    } t_lex_result;

endpackage

`default_nettype wire

/* src/ncl_step.sv */
// ncl_step: lexer state machine; one character per accepted transfer.
// Depends on ncl_pkg.
`default_nettype none

module ncl_step (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_acc,
    input  wire  [7:0]          i_char_code,
    output ncl_pkg::t_lex_result o_result
);
    import ncl_pkg::*;

    t_lex_state r_state, n_state;
    logic       r_frac, n_frac;

    logic  is_dig, is_letter, is_point, is_e, is_sign;
    t_kind cur_kind;

    assign is_dig    = (i_char_code >= C_ZERO) && (i_char_code <= C_NINE);
    assign is_letter = ((i_char_code >= C_UPPER_A) && (i_char_code <= C_UPPER_Z)) ||
                       ((i_char_code >= C_LOWER_A) && (i_char_code <= C_LOWER_Z));
    assign is_point  = (i_char_code == C_POINT);
    assign is_e      = (i_char_code == C_UPPER_E) || (i_char_code == C_LOWER_E);
    assign is_sign   = (i_char_code == C_MINUS) || (i_char_code == C_PLUS);
    assign cur_kind  = r_frac ? K_DBL : K_INT;

    // Result of this character.
    always_comb begin
        o_result = '{status: S_TAKEN, kind: K_NONE};
        unique case (r_state)
            ST_START: begin
                if (!is_dig && !is_point && (i_char_code != C_MINUS)) begin
                    o_result = '{status: S_ENDED, kind: K_NONE};
                end
            end
            ST_MINUS: begin
                if (!is_dig && !is_point) begin
                    o_result = '{status: S_NEGATE, kind: K_NONE};
                end
            end
            ST_ZERO: begin
                priority if (is_point) begin
                    o_result = '{status: S_TAKEN, kind: K_NONE};
                end else if (is_dig) begin
                    o_result = '{status: S_ERR_ZERO, kind: K_NONE};
                end else begin
                    o_result = '{status: S_ENDED, kind: cur_kind};
                end
            end
            ST_POINT: begin
                if (!is_dig) begin
                    o_result = '{status: S_ERR_POINT, kind: K_NONE};
                end
            end
            ST_MANT: begin
                if (!(is_point && !r_frac) && !is_e && !is_dig) begin
                    o_result = '{status: S_ENDED, kind: cur_kind};
                end
            end
            ST_EXP: begin
                priority if (is_sign || is_dig) begin
                    o_result = '{status: S_TAKEN, kind: K_NONE};
                end else if (is_letter) begin
                    o_result = '{status: S_POSSIBLE, kind: cur_kind};
                end else begin
                    o_result = '{status: S_ERR_EXP, kind: K_NONE};
                end
            end
            ST_EXPSIGN: begin
                if (!is_dig) begin
                    o_result = '{status: S_ERR_EXPSIGN, kind: K_NONE};
                end
            end
            ST_EXPDIG: begin
                if (!is_dig) begin
                    o_result = '{status: S_ENDED, kind: K_DBL};
                end
            end
        endcase
    end

    // Next state; any non-taken status returns to start.
    always_comb begin
        n_state = r_state;
        n_frac  = r_frac;
        unique case (r_state)
            ST_START, ST_MINUS: begin
                priority if ((r_state == ST_START) && (i_char_code == C_ZERO)) begin
                    n_state = ST_ZERO;
                end else if ((r_state == ST_START) && (i_char_code == C_MINUS)) begin
                    n_state = ST_MINUS;
                end else if (is_point) begin
                    n_state = ST_POINT;
                    n_frac  = 1'b1;
                end else if (is_dig) begin
                    n_state = ST_MANT;
                end else begin
                    n_state = r_state;
                end
            end
            ST_ZERO: begin
                if (is_point) begin
                    n_state = ST_MANT;
                    n_frac  = 1'b1;
                end
            end
            ST_POINT: begin
                if (is_dig) begin
                    n_state = ST_MANT;
                end
            end
            ST_MANT: begin
                priority if (is_point && !r_frac) begin
                    n_frac = 1'b1;
                end else if (is_e) begin
                    n_state = ST_EXP;
                end else begin
                    n_state = r_state;
                end
            end
            ST_EXP: begin
                priority if (is_sign) begin
                    n_state = ST_EXPSIGN;
                    n_frac  = 1'b1;
                end else if (is_dig) begin
                    n_state = ST_EXPDIG;
                    n_frac  = 1'b1;
                end else begin
                    n_state = r_state;
                end
            end
            ST_EXPSIGN: begin
                if (is_dig) begin
                    n_state = ST_EXPDIG;
                end
            end
            ST_EXPDIG: begin
                n_state = r_state;
            end
        endcase
        if (o_result.status != S_TAKEN) begin
            n_state = ST_START;
            n_frac  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_START;
            r_frac  <= 1'b0;
        end else if (i_acc) begin
            r_state <= n_state;
            r_frac  <= n_frac;
        end
    end

endmodule

`default_nettype wire

/* src/ncl_obuf.sv */
// ncl_obuf: result register plus skid register for the output channel.
// Depends on ncl_pkg.
`default_nettype none

module ncl_obuf (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  ncl_pkg::t_lex_result i_result,
    output logic                 o_full,
    output logic                 o_valid,
    input  wire                  i_stall,
    output ncl_pkg::t_lex_result o_result
);
    import ncl_pkg::*;

    logic        r_out_valid, r_skid_valid;
    t_lex_result r_out, r_skid;
    logic        out_free;

    assign out_free = !r_out_valid || !i_stall;
    assign o_full   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload: skid drains first, then new transfers.
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_result;
        end else if (i_push) begin
            r_skid <= i_result;
        end
    end

endmodule

`default_nettype wire

/* src/numeric_constant_lexer_top.sv */
// numeric_constant_lexer_top: numeric constant lexer, one character per transfer.
// Depends on ncl_pkg, ncl_step and ncl_obuf.
//
//  Channel | Valid   | Stall    | Payload
//  --------+---------+----------+----------------------------
//  input   | i_valid | o_stall  | i_char_code[7:0]
//  output  | o_valid | i_stall  | o_status[2:0], o_const_kind[1:0]
//
// One character is accepted per cycle while o_stall is low. The state machine
// steps in the cycle of the input transfer and its result is registered, in the
// output register or, while the output stalls, in the skid register.
// Reset (i_rst_n low at a clock edge) returns the lexer to start and empties
// the output registers. When the output stalls, one extra result is held in a
// skid register; o_stall rises only once that is occupied.
`default_nettype none

module numeric_constant_lexer_top (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_stall,
    input  wire  [7:0] i_char_code,
    output logic       o_valid,
    input  wire        i_stall,
    output logic [2:0] o_status,
    output logic [1:0] o_const_kind
);
    import ncl_pkg::*;

    logic        acc;
    logic        full;
    t_lex_result step_result;
    t_lex_result out_result;

    // Input transfer: only the skid register being occupied holds off input.
    assign o_stall = full;
    assign acc     = i_valid && !full;

    ncl_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc),
        .i_char_code (i_char_code),
        .o_result    (step_result)
    );

    ncl_obuf u_obuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (acc),
        .i_result (step_result),
        .o_full   (full),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (out_result)
    );

    assign o_status     = out_result.status;
    assign o_const_kind = out_result.kind;

endmodule

`default_nettype wire

/* dv/numeric_constant_lexer_top_test.sv */
// numeric_constant_lexer_top_test: self-checking bench for the numeric constant lexer.
// Needs ncl_pkg and numeric_constant_lexer_top; drives characters and scores results.
`default_nettype none

module numeric_constant_lexer_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import ncl_pkg::*;

    // Scoreboard: runs its own copy of the lexer state machine on every
    // accepted character and keeps the expected results in arrival order.
    class lexer_scoreboard;
        t_lex_state  scan_state;
        bit          is_double;
        t_lex_result expected_q[$];
        int          errors;

        function new();
            scan_state = ST_START;
            is_double  = 1'b0;
            errors     = 0;
        endfunction

        // Next result and next state for one character.
        function t_lex_result lex_char(logic [7:0] c);
            t_lex_result r;
            t_kind       sofar;
            logic        is_digit;
            logic        is_alpha;
            r.status = S_TAKEN;
            r.kind   = K_NONE;
            sofar    = is_double ? K_DBL : K_INT;
            is_digit = (c >= C_ZERO && c <= C_NINE);
            is_alpha = (c >= C_UPPER_A && c <= C_UPPER_Z) ||
                       (c >= C_LOWER_A && c <= C_LOWER_Z);
            case (scan_state)
                ST_START, ST_MINUS: begin
                    if (scan_state == ST_START && c == C_ZERO) begin
                        scan_state = ST_ZERO;
                    end else if (scan_state == ST_START && c == C_MINUS) begin
                        scan_state = ST_MINUS;
                    end else if (c == C_POINT) begin
                        is_double  = 1'b1;
                        scan_state = ST_POINT;
                    end else if (is_digit) begin
                        scan_state = ST_MANT;
                    end else begin
                        // nothing collected, or a minus with no number behind it
                        r.status = (scan_state == ST_START) ? S_ENDED : S_NEGATE;
                    end
                end
                ST_ZERO: begin
                    if (c == C_POINT) begin
                        is_double  = 1'b1;
                        scan_state = ST_MANT;
                    end else if (is_digit) begin
                        r.status = S_ERR_ZERO;
                    end else begin
                        r.status = S_ENDED;
                        r.kind   = sofar;
                    end
                end
                ST_POINT: begin
                    if (is_digit) scan_state = ST_MANT;
                    else r.status = S_ERR_POINT;
                end
                ST_MANT: begin
                    if (c == C_POINT && !is_double) begin
                        is_double = 1'b1;
                    end else if (c == C_UPPER_E || c == C_LOWER_E) begin
                        scan_state = ST_EXP;
                    end else if (!is_digit) begin
                        r.status = S_ENDED;
                        r.kind   = sofar;
                    end
                end
                ST_EXP: begin
                    if (c == C_MINUS || c == C_PLUS) begin
                        scan_state = ST_EXPSIGN;
                        is_double  = 1'b1;
                    end else if (is_digit) begin
                        scan_state = ST_EXPDIG;
                        is_double  = 1'b1;
                    end else if (is_alpha) begin
                        r.status = S_POSSIBLE;
                        r.kind   = sofar;
                    end else begin
                        r.status = S_ERR_EXP;
                    end
                end
                ST_EXPSIGN: begin
                    if (is_digit) scan_state = ST_EXPDIG;
                    else r.status = S_ERR_EXPSIGN;
                end
                default: begin
                    if (!is_digit) begin
                        r.status = S_ENDED;
                        r.kind   = K_DBL;
                    end
                end
            endcase
            if (r.status != S_TAKEN) begin
                scan_state = ST_START;
                is_double  = 1'b0;
            end
            return r;
        endfunction

        function void note_char(logic [7:0] c);
            expected_q.push_back(lex_char(c));
        endfunction

        function void check_result(logic [2:0] status, logic [1:0] kind);
            t_lex_result exp_r;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result status %0d kind %0d", $time, status, kind);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (status !== exp_r.status) begin
                $display("%0t: status expected %0d actual %0d", $time, exp_r.status, status);
                errors++;
            end
            if (kind !== exp_r.kind) begin
                $display("%0t: const_kind expected %0d actual %0d", $time, exp_r.kind, kind);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic [7:0] i_char_code  = 8'h00;
    logic       i_stall      = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [2:0] o_status;
    logic [1:0] o_const_kind;

    lexer_scoreboard sb = new();

    // Knobs the main sequence turns between phases.
    int  stall_pct    = 0;   // receiver back-pressure, percent of cycles
    int  gap_max      = 0;   // longest idle gap between sender bursts
    bit  hold_off_req = 1'b0;
    int  hold_left    = 0;
    int  burst_left   = 0;
    int  chars_sent   = 0;

    logic [7:0] text_q[$];   // characters waiting to be offered

    numeric_constant_lexer_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_char_code  (i_char_code),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_const_kind (o_const_kind)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Receiver. Normally random back-pressure at stall_pct; on request it
    // holds off for a long fixed stretch so the skid buffer fills and the
    // block has to stall the sender.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_off_req) begin
            hold_off_req <= 1'b0;
            hold_left    <= 48;
            i_stall      <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Output monitor: values read here are the ones from before the edge,
    // so the transfer condition is exactly what the block saw.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result(o_status, o_const_kind);
        end
    end

    // Offer one character and hold it until the transfer happens.
    task automatic send_char(input logic [7:0] c);
        i_valid     <= 1'b1;
        i_char_code <= c;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_char(c);
        chars_sent++;
    endtask

    // Sender pattern: bursts of random length, random gaps between them.
    // Payload is scrambled during gaps; valid is low so it does not matter.
    task automatic send_text();
        int gap;
        while (text_q.size() != 0) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(24, 1);
                gap        = $urandom_range(gap_max);
                if (gap != 0) begin
                    i_valid     <= 1'b0;
                    i_char_code <= 8'($urandom_range(255));
                    repeat (gap) @(posedge i_clk);
                end
            end
            send_char(text_q.pop_front());
            burst_left--;
        end
    endtask

    // Sender pauses until every result is back.
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_digit();
        return 8'(C_ZERO + $urandom_range(9));
    endfunction

    function automatic void push_digits(int lo, int hi);
        int n;
        n = $urandom_range(hi, lo);
        repeat (n) text_q.push_back(rand_digit());
    endfunction

    function automatic logic [7:0] rand_letter();
        return $urandom_range(1) ? 8'(C_UPPER_A + $urandom_range(25))
                                 : 8'(C_LOWER_A + $urandom_range(25));
    endfunction

    // Well-formed constant with random content, then a terminator. With
    // broken set, one character of it is replaced by an arbitrary byte.
    function automatic void build_constant(bit broken);
        int first;
        int pos;
        first = text_q.size();
        if ($urandom_range(3) == 0) text_q.push_back(C_MINUS);
        case ($urandom_range(2))
            0: begin
                text_q.push_back(C_ZERO);
                if ($urandom_range(1)) begin
                    text_q.push_back(C_POINT);
                    push_digits(0, 3);
                end
            end
            1: begin
                text_q.push_back(8'(C_ZERO + $urandom_range(9, 1)));
                push_digits(0, 4);
                if ($urandom_range(2) == 0) begin
                    text_q.push_back(C_POINT);
                    push_digits(0, 3);
                end
            end
            default: begin
                text_q.push_back(C_POINT);
                push_digits(1, 3);
            end
        endcase
        // a constant that is only a leading zero cannot take an exponent
        if (text_q[text_q.size() - 1] != C_ZERO || text_q.size() - first > 2) begin
            case ($urandom_range(4))
                0, 1: begin
                    text_q.push_back($urandom_range(1) ? C_UPPER_E : C_LOWER_E);
                    if ($urandom_range(1)) text_q.push_back($urandom_range(1) ? C_PLUS : C_MINUS);
                    push_digits(1, 3);
                end
                2: begin
                    // E then a letter: E given back as a possible operator
                    text_q.push_back($urandom_range(1) ? C_UPPER_E : C_LOWER_E);
                    text_q.push_back(rand_letter());
                end
                default: ;
            endcase
        end
        case ($urandom_range(3))
            0: text_q.push_back(8'h20);
            1: text_q.push_back(rand_letter());
            2: text_q.push_back(8'h29);
            default: text_q.push_back(8'($urandom_range(255)));
        endcase
        if (broken) begin
            pos = $urandom_range(text_q.size() - 1, first);
            text_q[pos] = 8'($urandom_range(255));
        end
    endfunction

    // Random characters until the running total reaches the target.
    task automatic random_phase(int target);
        int pick;
        while (chars_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 72) begin
                build_constant(1'b0);
            end else if (pick < 88) begin
                build_constant(1'b1);
            end else begin
                repeat ($urandom_range(4, 1)) text_q.push_back(8'($urandom_range(255)));
            end
            send_text();
        end
    endtask

    // Directed characters: one short case each for a set of paths through the lexer.
    task automatic directed_phase();
        text_q = '{
            C_MINUS, C_MINUS,                                // lone minus: negate operator
            C_ZERO, "q",                                     // letter ends a leading zero
            C_ZERO, "7",                                     // digit after leading zero
            C_MINUS, C_ZERO, C_POINT, "5", C_UPPER_E,
            C_PLUS, "9", 8'h00,                              // full double, ended by NUL
            C_POINT, "x",                                    // point with no digit after it
            "1", C_LOWER_E, "q",                             // E and letter, integer so far
            C_ZERO, C_POINT, C_UPPER_E, ",",                 // nothing valid after E
            "8", C_LOWER_E, C_MINUS, "/",                    // no digit after exponent sign
            "3", C_POINT, C_POINT,                           // second point ends it
            8'hFF                                            // high byte at start: no constant
        };
        send_text();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        stall_pct = 0;
        gap_max   = 0;
        directed_phase();
        drain();

        // moderate back-pressure, short gaps
        stall_pct = 30;
        gap_max   = 3;
        random_phase(530);

        // long receiver hold-off while the sender keeps streaming
        stall_pct    = 0;
        gap_max      = 0;
        burst_left   = 1000;
        hold_off_req <= 1'b1;
        random_phase(650);
        drain();
        burst_left = 0;

        // heavy back-pressure, longer gaps
        stall_pct = 70;
        gap_max   = 6;
        random_phase(1100);

        // full rate both ways
        stall_pct  = 0;
        gap_max    = 0;
        burst_left = 1000;
        random_phase(1400);
        burst_left = 0;

        // light mix
        stall_pct = 10;
        gap_max   = 2;
        random_phase(1680);

        drain();
        repeat (6) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("numeric_constant_lexer_top regression: pass");
        end else begin
            $display("numeric_constant_lexer_top regression: fail");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #500000;
        $display("numeric_constant_lexer_top regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
src/ncl_pkg.sv
src/ncl_step.sv
src/ncl_obuf.sv
src/numeric_constant_lexer_top.sv
dv/numeric_constant_lexer_top_test.sv
